// File: rtl/itoc_pkg.sv
// shared types and constants for the interval table overlap check
`default_nettype none
package itoc_pkg;

  localparam int unsigned BOUND_W     = 32;
  localparam int unsigned THRESH_W    = 31;
  localparam int unsigned STATUS_W    = 2;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 31'd100;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_DUP   = 2'd2,
    STATUS_FULL  = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EVAL = 2'b10
  } state_t;

  // commit strobes broadcast to every cell
  typedef struct packed {
    logic insert;
    logic clear;
  } cell_ctl_t;

endpackage
`default_nettype wire

// File: rtl/itoc_cell.sv
// one table slot: holds an interval, compares it with the pending item, shifts right on insert
`default_nettype none
module itoc_cell (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire itoc_pkg::cell_ctl_t            ctl,
  input  wire signed [itoc_pkg::BOUND_W-1:0]  item_low,
  input  wire signed [itoc_pkg::BOUND_W-1:0]  item_high,
  input  wire                                 prev_lt,
  input  wire                                 prev_valid,
  input  wire signed [itoc_pkg::BOUND_W-1:0]  prev_low,
  input  wire signed [itoc_pkg::BOUND_W-1:0]  prev_high,
  input  wire                                 next_lt,
  output logic                                lt,
  output logic                                valid,
  output logic signed [itoc_pkg::BOUND_W-1:0] low,
  output logic signed [itoc_pkg::BOUND_W-1:0] high,
  output logic                                pred_dup,
  output logic                                succ_dup
);
  import itoc_pkg::*;

  // entry sits left of the insertion point
  assign lt       = valid && (low < item_low);
  // last entry left of the point overlaps the new low bound
  assign pred_dup = lt && !next_lt && (high >= item_low);
  // first entry at or right of the point starts inside the new interval
  assign succ_dup = valid && !lt && prev_lt && (item_high >= low);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.insert && !lt) begin
      if (prev_lt) begin
        valid <= 1'b1;
      end else begin
        valid <= prev_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.insert && !lt) begin
      if (prev_lt) begin
        low  <= item_low;
        high <= item_high;
      end else begin
        low  <= prev_low;
        high <= prev_high;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/interval_table_overlap_check.sv
// top level of the interval table overlap check: item handshake, control and the cell row
`default_nettype none
// Keeps up to TABLE_DEPTH disjoint signed intervals sorted by lower bound in a
// row of cells. An insert item (tuser = 0) is checked for an empty range, a
// large span against the threshold register, overlap with its predecessor and
// successor, and a full table, then stored in order; a clear item (tuser = 1)
// empties the table. Every item yields exactly one result item. An item is
// accepted while idle, then evaluated: every cell compares its entry with the
// item at once and the row shifts right by one to open the slot. Evaluation
// repeats while the result register is still occupied downstream. Entries
// need no clearing after reset: each cell carries its own valid bit. The
// threshold may only be written while idle.
module interval_table_overlap_check #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire         clk,
  input  wire         rst,
  // threshold register write
  input  wire         cfg_wr_en,
  input  wire  [30:0] cfg_wr_data,
  // input items
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,  // low_bound [31:0], high_bound [63:32]
  input  wire  [0:0]  s_axis_tuser,  // cmd [0]
  // result items
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata   // status [1:0], conflict_value [33:2],
                                     // large_range [34], zero [39:35]
);
  import itoc_pkg::*;

  state_t state, state_next;

  logic [THRESH_W-1:0]        threshold;
  cmd_t                       item_cmd;
  logic signed [BOUND_W-1:0]  item_low;
  logic signed [BOUND_W-1:0]  item_high;

  // result register
  logic                       out_valid;
  status_t                    out_status;
  logic [BOUND_W-1:0]         out_conflict;
  logic                       out_large;

  // cell row
  logic [TABLE_DEPTH-1:0]     lt_vec, valid_vec, pred_vec, succ_vec;
  logic signed [BOUND_W-1:0]  low_arr  [TABLE_DEPTH];
  logic signed [BOUND_W-1:0]  high_arr [TABLE_DEPTH];
  cell_ctl_t                  ctl;

  // decision signals
  logic                       accept, out_free, commit;
  logic                       empty_rng, pred_any, succ_any, full, over_limit;
  logic signed [BOUND_W:0]    span;
  status_t                    res_status;
  logic [BOUND_W-1:0]         res_conflict;
  logic                       res_large;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign commit        = (state == ST_EVAL) && out_free;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  // latch the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd  <= cmd_t'(s_axis_tuser[0]);
      item_low  <= s_axis_tdata[31:0];
      item_high <= s_axis_tdata[63:32];
    end
  end

  // checks in priority order
  assign empty_rng  = item_low > item_high;
  assign span       = {item_high[BOUND_W-1], item_high} - {item_low[BOUND_W-1], item_low};
  assign over_limit = !empty_rng && (span > $signed({2'b00, threshold}));
  assign pred_any   = |pred_vec;
  assign succ_any   = |succ_vec;
  assign full       = valid_vec[TABLE_DEPTH-1];

  always_comb begin
    res_status   = STATUS_OK;
    res_conflict = '0;
    res_large    = 1'b0;
    ctl          = '0;
    if (item_cmd == CMD_CLEAR) begin
      ctl.clear = commit;
    end else if (empty_rng) begin
      res_status = STATUS_EMPTY;
    end else begin
      res_large = over_limit;
      if (pred_any) begin
        res_status   = STATUS_DUP;
        res_conflict = item_low;
      end else if (succ_any) begin
        res_status   = STATUS_DUP;
        res_conflict = item_high;
      end else if (full) begin
        res_status = STATUS_FULL;
      end else begin
        ctl.insert = commit;
      end
    end
  end

  // control
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result register: loads when the evaluation commits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status   <= res_status;
      out_conflict <= res_conflict;
      out_large    <= res_large;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_large, out_conflict, out_status};

  // row of cells, each sees its left and right neighbor
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic                      prev_lt, prev_valid, next_lt;
    logic signed [BOUND_W-1:0] prev_low, prev_high;

    if (i == 0) begin : g_first
      // left edge acts as an entry below every item
      assign prev_lt    = 1'b1;
      assign prev_valid = 1'b0;
      assign prev_low   = '0;
      assign prev_high  = '0;
    end else begin : g_inner
      assign prev_lt    = lt_vec[i-1];
      assign prev_valid = valid_vec[i-1];
      assign prev_low   = low_arr[i-1];
      assign prev_high  = high_arr[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign next_lt = 1'b0;
    end else begin : g_mid
      assign next_lt = lt_vec[i+1];
    end

    itoc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .item_low   (item_low),
      .item_high  (item_high),
      .prev_lt    (prev_lt),
      .prev_valid (prev_valid),
      .prev_low   (prev_low),
      .prev_high  (prev_high),
      .next_lt    (next_lt),
      .lt         (lt_vec[i]),
      .valid      (valid_vec[i]),
      .low        (low_arr[i]),
      .high       (high_arr[i]),
      .pred_dup   (pred_vec[i]),
      .succ_dup   (succ_vec[i])
    );
  end

  // occupied cells always form a prefix of the row
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec >> 1)) == (valid_vec >> 1))
    else $error("table valid bits not contiguous");

  // an insert adds exactly one entry
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.insert |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
    else $error("insert did not add one entry");

  // conflict value only carries data on a duplicate
  a_conflict_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != STATUS_DUP |-> out_conflict == '0)
    else $error("conflict value set without duplicate");

  // a clear leaves the table empty
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> valid_vec == '0)
    else $error("clear left entries behind");

endmodule
`default_nettype wire

// File: sim/interval_table_overlap_check_tb.sv
// self-checking testbench for the interval table overlap check
module interval_table_overlap_check_tb;
  import itoc_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam int STALL_LIMIT = 4000;   // cycles with no item moving on either side
  localparam int REPORT_MAX = 10;
  localparam logic signed [31:0] BOUND_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] BOUND_MAX = 32'sh7FFF_FFFF;
  localparam logic [30:0] LIMIT_MAX = 31'h7FFF_FFFF;

  // one result item as the block should return it
  typedef struct {
    status_t     status;
    logic [31:0] conflict;
    logic        over_limit;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [30:0] cfg_wr_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = CMD_INSERT;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  interval_table_overlap_check #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #4 clk = ~clk;

  // mirror of the block: sorted interval store and threshold register
  logic signed [31:0] stored_lo [DEPTH];
  logic signed [31:0] stored_hi [DEPTH];
  int unsigned stored_count = 0;
  logic [30:0] span_limit = THRESH_RESET;

  outcome_t pending_outcomes[$];
  outcome_t wanted;

  int failures = 0;
  int items_sent = 0;
  int limit_writes = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int large_seen = 0;
  int stalled_cycles = 0;
  bit steady_flow = 1'b0;   // no idling on either side while set

  // work out the result of one item and update the mirrored table
  function automatic outcome_t resolve_interval(input cmd_t c, input logic signed [31:0] lo,
                                                input logic signed [31:0] hi);
    outcome_t r;
    logic [32:0] span;
    int unsigned pos;
    r.status = STATUS_OK;
    r.conflict = '0;
    r.over_limit = 1'b0;
    if (c == CMD_CLEAR) begin
      stored_count = 0;
      return r;
    end
    if (lo > hi) begin
      r.status = STATUS_EMPTY;
      return r;
    end
    // exact span, never negative here
    span = {hi[31], hi} - {lo[31], lo};
    r.over_limit = span > span_limit;
    pos = 0;
    while (pos < stored_count && stored_lo[pos] < lo) pos++;
    // predecessor is looked at before the successor
    if (pos > 0 && stored_hi[pos-1] >= lo) begin
      r.status = STATUS_DUP;
      r.conflict = lo;
      return r;
    end
    if (pos < stored_count && hi >= stored_lo[pos]) begin
      r.status = STATUS_DUP;
      r.conflict = hi;
      return r;
    end
    if (stored_count >= DEPTH) begin
      r.status = STATUS_FULL;
      return r;
    end
    for (int unsigned i = stored_count; i > pos; i--) begin
      stored_lo[i] = stored_lo[i-1];
      stored_hi[i] = stored_hi[i-1];
    end
    stored_lo[pos] = lo;
    stored_hi[pos] = hi;
    stored_count++;
    return r;
  endfunction

  // offer one item, wait for the handshake, then record what should come back
  task automatic offer_interval(input cmd_t c, input logic signed [31:0] lo,
                                input logic signed [31:0] hi);
    // random gaps; besides drain_results, valid is only lowered here, never right after the accept
    while (!steady_flow && $urandom_range(0, 99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {hi, lo};
    s_axis_tuser <= c;
    do @(posedge clk); while (!s_axis_tready);
    pending_outcomes.push_back(resolve_interval(c, lo, hi));
    items_sent++;
  endtask

  // stop offering and wait until every result has arrived
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // threshold changes only while the block is idle
  task automatic write_limit(input logic [30:0] value);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    span_limit = value;
    limit_writes++;
    @(posedge clk);
  endtask

  task automatic flag_failure(input string msg);
    failures++;
    if (failures <= REPORT_MAX) $display("mismatch %0d at %0t: %s", failures, $realtime, msg);
  endtask

  // result side: random stalls, then compare against the oldest expectation
  always @(posedge clk) begin
    m_axis_tready <= steady_flow ? 1'b1 : ($urandom_range(0, 99) >= 11);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_outcomes.size() == 0) begin
        flag_failure($sformatf("result with nothing expected, data %h", m_axis_tdata));
      end else begin
        wanted = pending_outcomes.pop_front();
        status_seen[m_axis_tdata[1:0]]++;
        if (m_axis_tdata[34]) large_seen++;
        if (m_axis_tdata[1:0] !== wanted.status || m_axis_tdata[33:2] !== wanted.conflict ||
            m_axis_tdata[34] !== wanted.over_limit || m_axis_tdata[39:35] !== 5'd0) begin
          flag_failure($sformatf(
            "expected status %0d conflict %h large %0b, got status %0d conflict %h large %0b pad %h",
            wanted.status, wanted.conflict, wanted.over_limit, m_axis_tdata[1:0],
            m_axis_tdata[33:2], m_axis_tdata[34], m_axis_tdata[39:35]));
        end
      end
    end
  end

  // watchdog on cycles where no item moves
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    while (stalled_cycles < STALL_LIMIT) @(posedge clk);
    $display("no progress for %0d cycles, %0d results outstanding", STALL_LIMIT,
             pending_outcomes.size());
    $display("FAILURE");
    $finish;
  end

  // bound extremes, empty ranges, both overlap sides, span threshold edges, clear
  task automatic test_directed_bounds();
    offer_interval(CMD_INSERT, 0, 0);
    offer_interval(CMD_INSERT, BOUND_MIN, BOUND_MIN);
    offer_interval(CMD_INSERT, BOUND_MAX, BOUND_MAX);
    offer_interval(CMD_INSERT, BOUND_MIN, BOUND_MAX);   // hits successor, large span
    offer_interval(CMD_INSERT, 5, 4);                    // empty
    offer_interval(CMD_INSERT, BOUND_MAX, BOUND_MIN);   // empty, widest inversion
    offer_interval(CMD_INSERT, 10, 20);
    offer_interval(CMD_INSERT, 15, 30);                  // predecessor overlap
    offer_interval(CMD_INSERT, 5, 10);                   // successor overlap
    offer_interval(CMD_INSERT, 21, 21);                  // touching above
    offer_interval(CMD_INSERT, 9, 9);                    // touching below
    offer_interval(CMD_INSERT, 100, 300);                // large, stored
    offer_interval(CMD_INSERT, 400, 500);                // span equal to threshold
    offer_interval(CMD_INSERT, 600, 701);                // one past threshold
    offer_interval(CMD_INSERT, 150, 1000);               // large and rejected
    offer_interval(CMD_INSERT, -100, -1);
    offer_interval(CMD_CLEAR, BOUND_MAX, BOUND_MIN);    // bounds ignored
    offer_interval(CMD_INSERT, 1, 1);
    offer_interval(CMD_INSERT, 1, 1);                    // same single value again
    offer_interval(CMD_INSERT, -50, -40);
  endtask

  // fill every slot in shuffled order, then try three more
  task automatic test_table_full();
    logic signed [31:0] starts [DEPTH];
    logic signed [31:0] swap;
    int unsigned k;
    offer_interval(CMD_CLEAR, 0, 0);
    for (int i = 0; i < DEPTH; i++) starts[i] = 2000 + 10 * i;
    for (int i = DEPTH - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      swap = starts[i];
      starts[i] = starts[k];
      starts[k] = swap;
    end
    for (int i = 0; i < DEPTH; i++) offer_interval(CMD_INSERT, starts[i], starts[i] + 3);
    offer_interval(CMD_INSERT, -5000, -1000);    // full, with a large span
    offer_interval(CMD_INSERT, 2001, 2001);      // overlap wins over full
    offer_interval(CMD_INSERT, 2005, 2005);      // full, small span
    offer_interval(CMD_CLEAR, 0, 0);
  endtask

  // threshold at both ends of its range
  task automatic test_threshold_extremes();
    write_limit('0);
    offer_interval(CMD_CLEAR, 0, 0);
    offer_interval(CMD_INSERT, 7, 7);
    offer_interval(CMD_INSERT, 9, 10);
    write_limit(LIMIT_MAX);
    offer_interval(CMD_CLEAR, 0, 0);
    offer_interval(CMD_INSERT, BOUND_MIN, BOUND_MAX);
    offer_interval(CMD_INSERT, 0, BOUND_MAX);      // span exactly at the limit
    offer_interval(CMD_INSERT, -1, BOUND_MAX);     // one past the limit
    write_limit(THRESH_RESET);
  endtask

  // phases of clustered traffic so overlaps and full tables occur, mixed with
  // wide random bounds, empty ranges and clears
  task automatic test_random_traffic();
    logic [30:0] phase_limit [4];
    longint cluster_base [4];
    int clear_pct [4];
    longint a, b, w;
    int unsigned r;
    phase_limit = '{31'($urandom_range(0, 300)), 31'd0, LIMIT_MAX, 31'($urandom)};
    cluster_base = '{-64'sd2147483648, longint'($signed($urandom)) - 3000, 0,
                     64'sd2147483647 - 3000};
    if (cluster_base[1] < -64'sd2147483648) cluster_base[1] += 6000;
    clear_pct = '{4, 1, 2, 1};
    for (int ph = 0; ph < 4; ph++) begin
      write_limit(phase_limit[ph]);
      for (int n = 0; n < 240; n++) begin
        steady_flow = (n >= 100 && n < 170);
        r = $urandom_range(0, 99);
        if (r < clear_pct[ph]) begin
          offer_interval(CMD_CLEAR, $urandom, $urandom);
        end else if (r < 10) begin
          // wide random bounds, inverted unless equal
          a = longint'($signed($urandom));
          b = longint'($signed($urandom));
          if (a < b) begin
            w = a;
            a = b;
            b = w;
          end
          offer_interval(CMD_INSERT, a[31:0], b[31:0]);
        end else if (r < 20) begin
          a = longint'($signed($urandom));
          b = longint'($signed($urandom));
          if (a > b) begin
            w = a;
            a = b;
            b = w;
          end
          offer_interval(CMD_INSERT, a[31:0], b[31:0]);
        end else begin
          r = $urandom_range(0, 99);
          if (r < 70) w = $urandom_range(0, 8);
          else if (r < 95) w = $urandom_range(0, 200);
          else w = $urandom_range(0, 2000);
          a = cluster_base[ph] + $urandom_range(0, 600);
          b = a + w;
          offer_interval(CMD_INSERT, a[31:0], b[31:0]);
        end
      end
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_bounds();
    test_table_full();
    test_threshold_extremes();
    test_random_traffic();
    drain_results();
    repeat (12) @(posedge clk);
    if (pending_outcomes.size() != 0) begin
      flag_failure($sformatf("%0d results never arrived", pending_outcomes.size()));
    end
    $display("run covered %0d items over %0d threshold settings", items_sent, limit_writes);
    $display("results: %0d ok, %0d empty, %0d overlap, %0d full, %0d large spans, %0d bad",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], large_seen,
             failures);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/itoc_pkg.sv
rtl/itoc_cell.sv
rtl/interval_table_overlap_check.sv
sim/interval_table_overlap_check_tb.sv
